// File: src/amu_pkg.sv
package amu_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int CORDIC_STEPS   = 28;
    localparam int CORDIC_W       = 34;
    localparam int STEP_W         = 4;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [3:0] CMD_SET       = 4'd0;
    localparam logic [3:0] CMD_IDENTITY  = 4'd1;
    localparam logic [3:0] CMD_TRANSLATE = 4'd2;
    localparam logic [3:0] CMD_SCALE     = 4'd3;
    localparam logic [3:0] CMD_ROTATE    = 4'd4;
    localparam logic [3:0] CMD_INVERT    = 4'd5;
    localparam logic [3:0] CMD_TRANSFORM = 4'd6;
    localparam logic [3:0] CMD_DELTA     = 4'd7;
    localparam logic [3:0] CMD_READ      = 4'd8;

    localparam logic [3:0] OP_NOP           = 4'd0;
    localparam logic [3:0] OP_SET           = 4'd1;
    localparam logic [3:0] OP_IDENT         = 4'd2;
    localparam logic [3:0] OP_TRANS         = 4'd3;
    localparam logic [3:0] OP_LOAD_SCALE    = 4'd4;
    localparam logic [3:0] OP_LOAD_ROT      = 4'd5;
    localparam logic [3:0] OP_COMMIT_LIN    = 4'd6;
    localparam logic [3:0] OP_COMMIT_SH     = 4'd7;
    localparam logic [3:0] OP_DET_CHECK     = 4'd8;
    localparam logic [3:0] OP_COMMIT_INV_LIN = 4'd9;
    localparam logic [3:0] OP_COMMIT_INV_SH = 4'd10;
    localparam logic [3:0] OP_DOT           = 4'd11;
    localparam logic [3:0] OP_CORDIC        = 4'd12;
    localparam logic [3:0] OP_DIV           = 4'd13;
    localparam logic [3:0] OP_EMIT          = 4'd14;

    localparam logic ROW_AC = 1'b0;
    localparam logic ROW_BD = 1'b1;

    localparam logic [1:0] VEC_COL0 = 2'd0;
    localparam logic [1:0] VEC_COL1 = 2'd1;
    localparam logic [1:0] VEC_PT   = 2'd2;
    localparam logic [1:0] VEC_SH   = 2'd3;

    localparam logic [2:0] T_A    = 3'd0;
    localparam logic [2:0] T_B    = 3'd1;
    localparam logic [2:0] T_C    = 3'd2;
    localparam logic [2:0] T_D    = 3'd3;
    localparam logic [2:0] T_X    = 3'd4;
    localparam logic [2:0] T_Y    = 3'd5;
    localparam logic [2:0] T_NONE = 3'd7;

    localparam logic [1:0] NUM_D  = 2'd0;
    localparam logic [1:0] NUM_NB = 2'd1;
    localparam logic [1:0] NUM_NC = 2'd2;
    localparam logic [1:0] NUM_A  = 2'd3;

    localparam logic [2:0] OS_ZERO = 3'd0;
    localparam logic [2:0] OS_PT   = 3'd1;
    localparam logic [2:0] OS_DP   = 3'd2;
    localparam logic [2:0] OS_R0   = 3'd3;
    localparam logic [2:0] OS_R1   = 3'd4;
    localparam logic [2:0] OS_R2   = 3'd5;

    typedef struct packed {
        logic [3:0] op;
        logic       row;
        logic [1:0] vec;
        logic       det;
        logic [2:0] dst;
        logic [1:0] num;
        logic [2:0] osel;
        logic       olast;
        logic       wt;
        logic       fin;
    } uop_t;

    typedef struct packed {
        uop_t u;
        logic take;
    } ctl_cmd_t;

    typedef struct packed {
        logic done;
        logic out_free;
    } dp_status_t;

    function automatic logic signed [CORDIC_W-1:0] atan_turn(input logic [4:0] idx);
        logic signed [CORDIC_W-1:0] v;
        case (idx)
            5'd0:  v = 34'sd536870912;
            5'd1:  v = 34'sd316933406;
            5'd2:  v = 34'sd167458907;
            5'd3:  v = 34'sd85004756;
            5'd4:  v = 34'sd42667331;
            5'd5:  v = 34'sd21354465;
            5'd6:  v = 34'sd10679838;
            5'd7:  v = 34'sd5340245;
            5'd8:  v = 34'sd2670163;
            5'd9:  v = 34'sd1335087;
            5'd10: v = 34'sd667544;
            5'd11: v = 34'sd333772;
            5'd12: v = 34'sd166886;
            5'd13: v = 34'sd83443;
            5'd14: v = 34'sd41722;
            5'd15: v = 34'sd20861;
            5'd16: v = 34'sd10430;
            5'd17: v = 34'sd5215;
            5'd18: v = 34'sd2608;
            5'd19: v = 34'sd1304;
            5'd20: v = 34'sd652;
            5'd21: v = 34'sd326;
            5'd22: v = 34'sd163;
            5'd23: v = 34'sd81;
            5'd24: v = 34'sd41;
            5'd25: v = 34'sd20;
            5'd26: v = 34'sd10;
            5'd27: v = 34'sd5;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic uop_t op_u(input logic [3:0] op);
        uop_t u;
        u = '0;
        u.op = op;
        u.dst = T_NONE;
        return u;
    endfunction

    function automatic uop_t dot_u(input logic row, input logic [1:0] vec, input logic det,
                                   input logic [2:0] dst);
        uop_t u;
        u = op_u(OP_DOT);
        u.row = row;
        u.vec = vec;
        u.det = det;
        u.dst = dst;
        u.wt = 1'b1;
        return u;
    endfunction

    function automatic uop_t div_u(input logic [1:0] num, input logic [2:0] dst);
        uop_t u;
        u = op_u(OP_DIV);
        u.num = num;
        u.dst = dst;
        u.wt = 1'b1;
        return u;
    endfunction

    function automatic uop_t emit_u(input logic [2:0] osel, input logic last);
        uop_t u;
        u = op_u(OP_EMIT);
        u.osel = osel;
        u.olast = last;
        u.fin = last;
        return u;
    endfunction

    // Post-multiply of the linear part, then the translation through the new part.
    function automatic uop_t pm_step(input logic [STEP_W-1:0] k);
        uop_t u;
        unique case (k)
            4'd0:    u = dot_u(ROW_AC, VEC_COL0, 1'b0, T_A);
            4'd1:    u = dot_u(ROW_AC, VEC_COL1, 1'b0, T_C);
            4'd2:    u = dot_u(ROW_BD, VEC_COL0, 1'b0, T_B);
            4'd3:    u = dot_u(ROW_BD, VEC_COL1, 1'b0, T_D);
            4'd4:    u = op_u(OP_COMMIT_LIN);
            4'd5:    u = dot_u(ROW_AC, VEC_SH, 1'b0, T_X);
            4'd6:    u = dot_u(ROW_BD, VEC_SH, 1'b0, T_Y);
            4'd7:    u = op_u(OP_COMMIT_SH);
            default: u = emit_u(OS_ZERO, 1'b1);
        endcase
        return u;
    endfunction

    function automatic uop_t ucode(input logic [3:0] cmd, input logic [STEP_W-1:0] step);
        uop_t u;
        unique case (cmd)
            CMD_SET:       u = (step == '0) ? op_u(OP_SET) : emit_u(OS_ZERO, 1'b1);
            CMD_IDENTITY:  u = (step == '0) ? op_u(OP_IDENT) : emit_u(OS_ZERO, 1'b1);
            CMD_TRANSLATE: u = (step == '0) ? op_u(OP_TRANS) : emit_u(OS_ZERO, 1'b1);
            CMD_SCALE:     u = (step == '0) ? op_u(OP_LOAD_SCALE) : pm_step(step - 4'd1);
            CMD_ROTATE: begin
                if (step == 4'd0) begin
                    u = op_u(OP_CORDIC);
                    u.wt = 1'b1;
                end else if (step == 4'd1) begin
                    u = op_u(OP_LOAD_ROT);
                end else begin
                    u = pm_step(step - 4'd2);
                end
            end
            CMD_INVERT: begin
                unique case (step)
                    4'd0:    u = dot_u(ROW_AC, VEC_SH, 1'b1, T_NONE);
                    4'd1:    u = op_u(OP_DET_CHECK);
                    4'd2:    u = div_u(NUM_D, T_A);
                    4'd3:    u = div_u(NUM_NB, T_B);
                    4'd4:    u = div_u(NUM_NC, T_C);
                    4'd5:    u = div_u(NUM_A, T_D);
                    4'd6:    u = op_u(OP_COMMIT_INV_LIN);
                    4'd7:    u = dot_u(ROW_AC, VEC_SH, 1'b0, T_X);
                    4'd8:    u = dot_u(ROW_BD, VEC_SH, 1'b0, T_Y);
                    4'd9:    u = op_u(OP_COMMIT_INV_SH);
                    default: u = emit_u(OS_ZERO, 1'b1);
                endcase
            end
            CMD_TRANSFORM, CMD_DELTA: begin
                unique case (step)
                    4'd0:    u = dot_u(ROW_AC, VEC_PT, 1'b0, T_X);
                    4'd1:    u = dot_u(ROW_BD, VEC_PT, 1'b0, T_Y);
                    default: u = emit_u((cmd == CMD_DELTA) ? OS_DP : OS_PT, 1'b1);
                endcase
            end
            CMD_READ: begin
                unique case (step)
                    4'd0:    u = emit_u(OS_R0, 1'b0);
                    4'd1:    u = emit_u(OS_R1, 1'b0);
                    default: u = emit_u(OS_R2, 1'b1);
                endcase
            end
            default: u = emit_u(OS_ZERO, 1'b1);
        endcase
        return u;
    endfunction

endpackage

// File: src/amu_divider.sv
module amu_divider
    import amu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [32:0] num,
    input  logic signed [64:0] den,
    output logic signed [31:0] quot,
    output logic               done
);

    localparam int DW = 32 + 2 * FRAC_BITS;
    localparam int CW = $clog2(DW + 1);

    logic          busy_reg;
    logic          fin_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] dvd_reg;
    logic [63:0]   r_reg;
    logic [63:0]   m_reg;
    logic [31:0]   q_reg;
    logic          big_reg;
    logic          neg_reg;

    logic [32:0]   num_mag;
    logic [64:0]   den_mag;
    logic [64:0]   r_shift;
    logic [64:0]   r_diff;
    logic          ge;

    assign num_mag = num[32] ? 33'(-num) : 33'(num);
    assign den_mag = den[64] ? 65'(-den) : 65'(den);
    assign r_shift = {r_reg, dvd_reg[DW-1]};
    assign r_diff  = r_shift - {1'b0, m_reg};
    assign ge      = (r_shift >= {1'b0, m_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            fin_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DW - 1)) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= {num_mag[31:0], {(2 * FRAC_BITS){1'b0}}};
            m_reg   <= den_mag[63:0];
            r_reg   <= '0;
            q_reg   <= '0;
            big_reg <= 1'b0;
            neg_reg <= num[32] ^ den[64];
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
            r_reg   <= ge ? r_diff[63:0] : r_shift[63:0];
            q_reg   <= {q_reg[30:0], ge};
            big_reg <= big_reg | q_reg[31];
        end
    end

    always_comb begin
        if (!neg_reg) begin
            quot = (big_reg || q_reg[31]) ? 32'sh7FFFFFFF : $signed(q_reg);
        end else if (big_reg || (q_reg[31] && (q_reg[30:0] != '0))) begin
            quot = 32'sh80000000;
        end else begin
            quot = $signed(-q_reg);
        end
    end

    assign done = fin_reg;

endmodule

// File: src/amu_cordic.sv
module amu_cordic
    import amu_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [15:0]        angle,
    output logic signed [31:0] cos_q,
    output logic signed [31:0] sin_q,
    output logic               done
);

    localparam int RK = 30 - FRAC_BITS;

    logic                       run_reg;
    logic                       fin_reg;
    logic [4:0]                 i_reg;
    logic signed [CORDIC_W-1:0] x_reg;
    logic signed [CORDIC_W-1:0] y_reg;
    logic signed [CORDIC_W-1:0] z_reg;
    logic [1:0]                 quad_reg;

    logic [31:0]                theta;
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    logic signed [CORDIC_W-1:0] c_raw;
    logic signed [CORDIC_W-1:0] s_raw;

    function automatic logic signed [31:0] round_q(input logic signed [CORDIC_W-1:0] v);
        logic signed [CORDIC_W:0] t;
        t = (CORDIC_W + 1)'(v) + ((CORDIC_W + 1)'(1) <<< (RK - 1));
        t = t >>> RK;
        if (t > (CORDIC_W + 1)'(32'sh7FFFFFFF)) begin
            return 32'sh7FFFFFFF;
        end else if (t < (CORDIC_W + 1)'(32'sh80000000)) begin
            return 32'sh80000000;
        end
        return t[31:0];
    endfunction

    assign theta = 32'(angle) << (32 - ANGLE_BITS);
    assign dx    = y_reg >>> i_reg;
    assign dy    = x_reg >>> i_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            fin_reg <= 1'b0;
            i_reg   <= '0;
        end else begin
            fin_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                i_reg   <= '0;
            end else if (run_reg) begin
                i_reg <= i_reg + 5'd1;
                if (i_reg == 5'(CORDIC_STEPS - 1)) begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= $signed({4'b0000, theta[29:0]});
            quad_reg <= theta[31:30];
        end else if (run_reg) begin
            if (!z_reg[CORDIC_W-1]) begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_turn(i_reg);
            end else begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_turn(i_reg);
            end
        end
    end

    always_comb begin
        case (quad_reg)
            2'd1: begin
                c_raw = -y_reg;
                s_raw = x_reg;
            end
            2'd2: begin
                c_raw = -x_reg;
                s_raw = -y_reg;
            end
            2'd3: begin
                c_raw = y_reg;
                s_raw = -x_reg;
            end
            default: begin
                c_raw = x_reg;
                s_raw = y_reg;
            end
        endcase
    end

    assign cos_q = round_q(c_raw);
    assign sin_q = round_q(s_raw);
    assign done  = fin_reg;

endmodule

// File: src/amu_datapath.sv
module amu_datapath
    import amu_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ctl_cmd_t           cmd,
    output dp_status_t         status,
    input  logic signed [31:0] s_first_value,
    input  logic signed [31:0] s_second_value,
    input  logic signed [31:0] s_third_value,
    input  logic signed [31:0] s_fourth_value,
    input  logic signed [31:0] s_fifth_value,
    input  logic signed [31:0] s_sixth_value,
    input  logic [15:0]        s_angle,
    input  logic               m_ready,
    output logic               m_valid,
    output logic signed [31:0] m_out_x,
    output logic signed [31:0] m_out_y,
    output logic               m_singular,
    output logic               m_last
);

    localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] QMAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] QMIN = 32'sh80000000;

    logic signed [31:0] in1_reg, in2_reg, in3_reg, in4_reg, in5_reg, in6_reg;
    logic [15:0]        angle_reg;
    logic signed [31:0] a_reg, b_reg, c_reg, d_reg, sx_reg, sy_reg;
    logic               sing_reg;
    logic signed [31:0] ra_reg, rb_reg, rc_reg, rd_reg;
    logic signed [31:0] t_reg [6];
    logic [2:0]         ph_reg;
    logic               row_reg;
    logic [1:0]         vec_reg;
    logic               detsel_reg;
    logic [2:0]         dst_reg;
    logic signed [63:0] prod_reg;
    logic signed [65:0] acc_reg;
    logic signed [64:0] det_reg;
    logic               m_valid_reg;
    logic signed [31:0] m_x_reg, m_y_reg;
    logic               m_sing_reg, m_last_reg;

    logic signed [31:0] r1, r2, v0, v1, mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic               dot_done;
    logic signed [31:0] dot_q;
    logic signed [32:0] div_num;
    logic signed [31:0] div_q;
    logic               div_done;
    logic signed [31:0] cs, sn;
    logic               cor_done;
    logic               out_free;
    logic               emit;

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] x,
                                                   input logic signed [31:0] y);
        logic signed [32:0] s;
        s = 33'(x) + 33'(y);
        if (s > 33'(QMAX)) begin
            return QMAX;
        end else if (s < 33'(QMIN)) begin
            return QMIN;
        end
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] neg_sat(input logic signed [31:0] x);
        return (x == QMIN) ? QMAX : -x;
    endfunction

    function automatic logic signed [31:0] round_acc(input logic signed [65:0] v);
        logic signed [66:0] s;
        s = 67'(v) + (67'sd1 <<< (FRAC_BITS - 1));
        s = s >>> FRAC_BITS;
        if (s > 67'(QMAX)) begin
            return QMAX;
        end else if (s < 67'(QMIN)) begin
            return QMIN;
        end
        return s[31:0];
    endfunction

    amu_divider #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (cmd.u.op == OP_DIV),
        .num    (div_num),
        .den    (det_reg),
        .quot   (div_q),
        .done   (div_done)
    );

    amu_cordic #(
        .FRAC_BITS (FRAC_BITS),
        .ANGLE_BITS(ANGLE_BITS)
    ) u_cordic (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (cmd.u.op == OP_CORDIC),
        .angle  (angle_reg),
        .cos_q  (cs),
        .sin_q  (sn),
        .done   (cor_done)
    );

    always_comb begin
        case (cmd.u.num)
            NUM_D:   div_num = 33'(d_reg);
            NUM_NB:  div_num = -33'(b_reg);
            NUM_NC:  div_num = -33'(c_reg);
            default: div_num = 33'(a_reg);
        endcase
    end

    always_comb begin
        r1 = (row_reg == ROW_BD) ? b_reg : a_reg;
        r2 = (row_reg == ROW_BD) ? d_reg : c_reg;
        case (vec_reg)
            VEC_COL0: begin
                v0 = ra_reg;
                v1 = rb_reg;
            end
            VEC_COL1: begin
                v0 = rc_reg;
                v1 = rd_reg;
            end
            VEC_PT: begin
                v0 = in1_reg;
                v1 = in2_reg;
            end
            default: begin
                v0 = sx_reg;
                v1 = sy_reg;
            end
        endcase
        if (detsel_reg) begin
            r1 = a_reg;
            v0 = d_reg;
            r2 = c_reg;
            v1 = b_reg;
        end
        mul_a = (ph_reg == 3'd1) ? r1 : r2;
        mul_b = (ph_reg == 3'd1) ? v0 : v1;
    end

    assign mul_p    = mul_a * mul_b;
    assign dot_done = (ph_reg == 3'd4);
    assign dot_q    = round_acc(acc_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = (cmd.u.op == OP_EMIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg       <= ONE;
            b_reg       <= '0;
            c_reg       <= '0;
            d_reg       <= ONE;
            sx_reg      <= '0;
            sy_reg      <= '0;
            sing_reg    <= 1'b0;
            ph_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.u.op == OP_DOT) begin
                ph_reg <= 3'd1;
            end else if (ph_reg == 3'd4) begin
                ph_reg <= '0;
            end else if (ph_reg != '0) begin
                ph_reg <= ph_reg + 3'd1;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (cmd.u.op)
                OP_SET: begin
                    a_reg  <= in1_reg;
                    b_reg  <= in2_reg;
                    c_reg  <= in3_reg;
                    d_reg  <= in4_reg;
                    sx_reg <= in5_reg;
                    sy_reg <= in6_reg;
                end
                OP_IDENT: begin
                    a_reg  <= ONE;
                    b_reg  <= '0;
                    c_reg  <= '0;
                    d_reg  <= ONE;
                    sx_reg <= '0;
                    sy_reg <= '0;
                end
                OP_TRANS: begin
                    sx_reg <= add_sat(sx_reg, in1_reg);
                    sy_reg <= add_sat(sy_reg, in2_reg);
                end
                OP_COMMIT_LIN: begin
                    a_reg <= t_reg[T_A];
                    b_reg <= t_reg[T_B];
                    c_reg <= t_reg[T_C];
                    d_reg <= t_reg[T_D];
                end
                OP_COMMIT_SH: begin
                    sx_reg <= t_reg[T_X];
                    sy_reg <= t_reg[T_Y];
                end
                OP_DET_CHECK: begin
                    sing_reg <= (acc_reg == '0);
                end
                OP_COMMIT_INV_LIN: begin
                    if (!sing_reg) begin
                        a_reg <= t_reg[T_A];
                        b_reg <= t_reg[T_B];
                        c_reg <= t_reg[T_C];
                        d_reg <= t_reg[T_D];
                    end
                end
                OP_COMMIT_INV_SH: begin
                    if (!sing_reg) begin
                        sx_reg <= neg_sat(t_reg[T_X]);
                        sy_reg <= neg_sat(t_reg[T_Y]);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            in1_reg   <= s_first_value;
            in2_reg   <= s_second_value;
            in3_reg   <= s_third_value;
            in4_reg   <= s_fourth_value;
            in5_reg   <= s_fifth_value;
            in6_reg   <= s_sixth_value;
            angle_reg <= s_angle;
        end
        if (cmd.u.op == OP_LOAD_SCALE) begin
            ra_reg <= in1_reg;
            rb_reg <= '0;
            rc_reg <= '0;
            rd_reg <= in2_reg;
        end else if (cmd.u.op == OP_LOAD_ROT) begin
            ra_reg <= cs;
            rb_reg <= sn;
            rc_reg <= neg_sat(sn);
            rd_reg <= cs;
        end
        if (cmd.u.op == OP_DOT) begin
            row_reg    <= cmd.u.row;
            vec_reg    <= cmd.u.vec;
            detsel_reg <= cmd.u.det;
        end
        if (cmd.u.op == OP_DOT || cmd.u.op == OP_DIV) begin
            dst_reg <= cmd.u.dst;
        end
        if (cmd.u.op == OP_DET_CHECK) begin
            det_reg <= acc_reg[64:0];
        end
        prod_reg <= mul_p;
        if (ph_reg == 3'd2) begin
            acc_reg <= 66'(prod_reg);
        end else if (ph_reg == 3'd3) begin
            acc_reg <= detsel_reg ? acc_reg - 66'(prod_reg) : acc_reg + 66'(prod_reg);
        end
        if (dst_reg != T_NONE) begin
            if (dot_done) begin
                t_reg[dst_reg] <= dot_q;
            end else if (div_done) begin
                t_reg[dst_reg] <= div_q;
            end
        end
        if (emit) begin
            m_sing_reg <= sing_reg;
            m_last_reg <= cmd.u.olast;
            case (cmd.u.osel)
                OS_PT: begin
                    m_x_reg <= add_sat(t_reg[T_X], sx_reg);
                    m_y_reg <= add_sat(t_reg[T_Y], sy_reg);
                end
                OS_DP: begin
                    m_x_reg <= t_reg[T_X];
                    m_y_reg <= t_reg[T_Y];
                end
                OS_R0: begin
                    m_x_reg <= a_reg;
                    m_y_reg <= b_reg;
                end
                OS_R1: begin
                    m_x_reg <= c_reg;
                    m_y_reg <= d_reg;
                end
                OS_R2: begin
                    m_x_reg <= sx_reg;
                    m_y_reg <= sy_reg;
                end
                default: begin
                    m_x_reg <= '0;
                    m_y_reg <= '0;
                end
            endcase
        end
    end

    assign status.done     = dot_done | div_done | cor_done;
    assign status.out_free = out_free;

    assign m_valid    = m_valid_reg;
    assign m_out_x    = m_x_reg;
    assign m_out_y    = m_y_reg;
    assign m_singular = m_sing_reg;
    assign m_last     = m_last_reg;

endmodule

// File: src/amu_controller.sv
module amu_controller
    import amu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [3:0] s_command,
    output logic       s_ready,
    input  dp_status_t status,
    output ctl_cmd_t   cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [3:0]        cmd_reg, cmd_next;
    logic [STEP_W-1:0] step_reg, step_next;
    uop_t              u;

    assign u = ucode(cmd_reg, step_reg);

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        step_next  = step_reg;
        s_ready    = 1'b0;
        cmd.take   = 1'b0;
        cmd.u      = op_u(OP_NOP);
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take   = 1'b1;
                    cmd_next   = s_command;
                    step_next  = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (u.op != OP_EMIT || status.out_free) begin
                    cmd.u = u;
                    if (u.wt) begin
                        state_next = ST_WAIT;
                    end else if (u.fin) begin
                        state_next = ST_IDLE;
                    end else begin
                        step_next = step_reg + 4'd1;
                    end
                end
            end
            ST_WAIT: begin
                if (status.done) begin
                    if (u.fin) begin
                        state_next = ST_IDLE;
                    end else begin
                        step_next  = step_reg + 4'd1;
                        state_next = ST_ISSUE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cmd_reg   <= CMD_SET;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            step_reg  <= step_next;
        end
    end

endmodule

// File: src/affine_matrix_unit.sv
// Commands run one at a time; the next command is taken once the last result
// is in the output register. Scale and rotate post-multiply the matrix through dot
// products; rotate first runs the 28-step CORDIC, and invert divides through the determinant.
// Synchronous active-low reset loads the identity matrix and clears the singular flag.
module affine_matrix_unit
    import amu_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_command,
    input  logic signed [31:0] s_first_value,
    input  logic signed [31:0] s_second_value,
    input  logic signed [31:0] s_third_value,
    input  logic signed [31:0] s_fourth_value,
    input  logic signed [31:0] s_fifth_value,
    input  logic signed [31:0] s_sixth_value,
    input  logic [15:0]        s_angle,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_x,
    output logic signed [31:0] m_out_y,
    output logic               m_singular,
    output logic               m_last
);

    ctl_cmd_t   cmd;
    dp_status_t status;

    amu_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_command(s_command),
        .s_ready  (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    amu_datapath #(
        .FRAC_BITS (FRAC_BITS),
        .ANGLE_BITS(ANGLE_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_first_value (s_first_value),
        .s_second_value(s_second_value),
        .s_third_value (s_third_value),
        .s_fourth_value(s_fourth_value),
        .s_fifth_value (s_fifth_value),
        .s_sixth_value (s_sixth_value),
        .s_angle       (s_angle),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_out_x       (m_out_x),
        .m_out_y       (m_out_y),
        .m_singular    (m_singular),
        .m_last        (m_last)
    );

    // A new transfer is taken only while no datapath operation is issued.
    a_take_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> (cmd.u.op == OP_NOP))
        else $error("command taken while an operation is issued");

    // A result is loaded only when the output register is free.
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.u.op == OP_EMIT) |-> status.out_free)
        else $error("result loaded over a pending transfer");

    // Unit completion only occurs while a command is in progress.
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        status.done |-> !s_ready)
        else $error("unit completion while idle");

endmodule

// File: tb/sv/affine_matrix_unit_tb.sv
module affine_matrix_unit_tb;
    import amu_pkg::*;

    localparam int FB = 16;
    localparam logic signed [31:0] Q_ONE = 32'sd65536;
    localparam longint LIMIT = 2000000;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               sing;
        logic               lst;
    } amu_result_t;

    class matrix_scoreboard;
        logic signed [31:0] ma, mb, mc, md, tx, ty;
        logic sing;
        amu_result_t pending[$];
        int errors;
        int checked;

        function new();
            ma = Q_ONE; mb = 0; mc = 0; md = Q_ONE; tx = 0; ty = 0;
            sing = 0; errors = 0; checked = 0;
        endfunction

        function logic signed [31:0] sat(logic signed [127:0] v);
            if (v > 128'sd2147483647) return 32'sh7fffffff;
            if (v < -128'sd2147483648) return 32'sh80000000;
            return v[31:0];
        endfunction

        function logic signed [31:0] rnd(logic signed [127:0] v, int k);
            logic signed [127:0] h;
            h = 128'sd1 <<< (k - 1);
            return sat((v + h) >>> k);
        endfunction

        // Exact sum of two products, rounded half up and saturated.
        function logic signed [31:0] dot(logic signed [31:0] x1, logic signed [31:0] y1,
                                         logic signed [31:0] x2, logic signed [31:0] y2);
            logic signed [127:0] s;
            s = 128'(x1) * 128'(y1) + 128'(x2) * 128'(y2);
            return rnd(s, FB);
        endfunction

        function logic signed [31:0] add_s(logic signed [31:0] x, logic signed [31:0] y);
            return sat(128'(x) + 128'(y));
        endfunction

        function logic signed [31:0] neg_s(logic signed [31:0] x);
            return sat(-128'(x));
        endfunction

        // Quotient truncated toward zero; the 128-bit dividend covers the full range.
        function logic signed [31:0] divq(logic signed [127:0] num, logic signed [127:0] den);
            logic signed [127:0] q;
            logic [127:0] n, m;
            logic neg;
            neg = (num < 0) != (den < 0);
            n = (num < 0) ? -num : num;
            m = (den < 0) ? -den : den;
            q = (n << (2 * FB)) / m;
            return sat(neg ? -q : q);
        endfunction

        function void sincos(logic [15:0] ang, output logic signed [31:0] cs,
                             output logic signed [31:0] sn);
            logic [31:0] theta;
            logic [1:0] quad;
            logic signed [127:0] x, y, z, dx, dy, c, s;
            theta = {ang, 16'h0};
            quad = theta[31:30];
            x = 652032874; y = 0; z = theta[29:0];
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = y >>> i; dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= 128'(atan_turn(i[4:0]));
                end else begin
                    x += dx; y -= dy; z += 128'(atan_turn(i[4:0]));
                end
            end
            case (quad)
                2'd1: begin c = -y; s = x; end
                2'd2: begin c = -x; s = -y; end
                2'd3: begin c = y; s = -x; end
                default: begin c = x; s = y; end
            endcase
            cs = rnd(c, 30 - FB);
            sn = rnd(s, 30 - FB);
        endfunction

        function void post_mul(logic signed [31:0] ra, logic signed [31:0] rb,
                               logic signed [31:0] rc, logic signed [31:0] rd);
            logic signed [31:0] na, nb, nc, nd, ox, oy;
            na = dot(ma, ra, mc, rb); nc = dot(ma, rc, mc, rd);
            nb = dot(mb, ra, md, rb); nd = dot(mb, rc, md, rd);
            ox = tx; oy = ty;
            ma = na; mb = nb; mc = nc; md = nd;
            tx = dot(na, ox, nc, oy);
            ty = dot(nb, ox, nd, oy);
        endfunction

        function void push(logic signed [31:0] x, logic signed [31:0] y, logic l);
            amu_result_t r;
            r.x = x; r.y = y; r.sing = sing; r.lst = l;
            pending.push_back(r);
        endfunction

        function void note_command(logic [3:0] cmd, logic signed [31:0] v1,
                                   logic signed [31:0] v2, logic signed [31:0] v3,
                                   logic signed [31:0] v4, logic signed [31:0] v5,
                                   logic signed [31:0] v6, logic [15:0] ang);
            logic signed [31:0] cs, sn, na, nb, nc, nd, ox, oy;
            logic signed [127:0] det;
            case (cmd)
                CMD_SET: begin
                    ma = v1; mb = v2; mc = v3; md = v4; tx = v5; ty = v6;
                end
                CMD_IDENTITY: begin
                    ma = Q_ONE; mb = 0; mc = 0; md = Q_ONE; tx = 0; ty = 0;
                end
                CMD_TRANSLATE: begin
                    tx = add_s(tx, v1); ty = add_s(ty, v2);
                end
                CMD_SCALE: post_mul(v1, 0, 0, v2);
                CMD_ROTATE: begin
                    sincos(ang, cs, sn);
                    post_mul(cs, sn, neg_s(sn), cs);
                end
                CMD_INVERT: begin
                    det = 128'(ma) * 128'(md) - 128'(mc) * 128'(mb);
                    if (det == 0) begin
                        sing = 1;
                    end else begin
                        sing = 0;
                        na = divq(128'(md), det); nb = divq(-128'(mb), det);
                        nc = divq(-128'(mc), det); nd = divq(128'(ma), det);
                        ox = tx; oy = ty;
                        ma = na; mb = nb; mc = nc; md = nd;
                        tx = neg_s(dot(na, ox, nc, oy));
                        ty = neg_s(dot(nb, ox, nd, oy));
                    end
                end
                CMD_TRANSFORM: begin
                    push(add_s(dot(ma, v1, mc, v2), tx), add_s(dot(mb, v1, md, v2), ty), 1);
                    return;
                end
                CMD_DELTA: begin
                    push(dot(ma, v1, mc, v2), dot(mb, v1, md, v2), 1);
                    return;
                end
                CMD_READ: begin
                    push(ma, mb, 0); push(mc, md, 0); push(tx, ty, 1);
                    return;
                end
                default: ;
            endcase
            push(0, 0, 1);
        endfunction

        function void check_result(logic signed [31:0] x, logic signed [31:0] y,
                                   logic s, logic l);
            amu_result_t e;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected transfer x=%h y=%h", $time, x, y);
                return;
            end
            e = pending.pop_front();
            if (x !== e.x) begin
                errors++;
                $display("%0t: out_x expected %h actual %h", $time, e.x, x);
            end
            if (y !== e.y) begin
                errors++;
                $display("%0t: out_y expected %h actual %h", $time, e.y, y);
            end
            if (s !== e.sing) begin
                errors++;
                $display("%0t: singular expected %b actual %b", $time, e.sing, s);
            end
            if (l !== e.lst) begin
                errors++;
                $display("%0t: last expected %b actual %b", $time, e.lst, l);
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [3:0] s_command = 0;
    logic signed [31:0] s_first_value = 0, s_second_value = 0, s_third_value = 0;
    logic signed [31:0] s_fourth_value = 0, s_fifth_value = 0, s_sixth_value = 0;
    logic [15:0] s_angle = 0;
    logic m_valid;
    logic m_ready = 0;
    logic signed [31:0] m_out_x, m_out_y;
    logic m_singular, m_last;

    matrix_scoreboard board;
    longint cycles = 0;
    int hold_off = 0;
    bit calm = 0;
    int sent = 0;

    affine_matrix_unit uut (.*);

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_out_x, m_out_y, m_singular, m_last);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 0;
        end else begin
            m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 20);
        end
    end

    task automatic send_command(logic [3:0] cmd, logic signed [31:0] v1, logic signed [31:0] v2,
                                logic signed [31:0] v3, logic signed [31:0] v4,
                                logic signed [31:0] v5, logic signed [31:0] v6,
                                logic [15:0] ang);
        while (!calm && $urandom_range(99) < 20) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_command <= cmd;
        s_first_value <= v1; s_second_value <= v2; s_third_value <= v3;
        s_fourth_value <= v4; s_fifth_value <= v5; s_sixth_value <= v6;
        s_angle <= ang;
        do @(posedge aclk); while (!s_ready);
        board.note_command(cmd, v1, v2, v3, v4, v5, v6, ang);
        sent++;
    endtask

    function automatic logic signed [31:0] rand_q(int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(262143)) - 32'sd131072;
            2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(8191)) - 32'sd4096 + Q_ONE;
        endcase
    endfunction

    task automatic simple(logic [3:0] cmd, logic signed [31:0] v1 = 0,
                          logic signed [31:0] v2 = 0, logic [15:0] ang = 0);
        send_command(cmd, v1, v2, 0, 0, 0, 0, ang);
    endtask

    initial begin
        int m;
        logic [3:0] cmd;
        board = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        simple(CMD_READ);
        simple(CMD_TRANSFORM, 32'sh7fffffff, 32'sh80000000);
        send_command(CMD_SET, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                     32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0);
        simple(CMD_TRANSFORM, 32'sh7fffffff, 32'sh7fffffff);
        simple(CMD_DELTA, 32'sh80000000, 32'sh7fffffff);
        simple(CMD_TRANSLATE, 32'sh7fffffff, 32'sh80000000);
        simple(CMD_READ);
        send_command(CMD_SET, Q_ONE, 2 * Q_ONE, 2 * Q_ONE, 4 * Q_ONE, Q_ONE, 0, 0);
        simple(CMD_INVERT);
        simple(CMD_READ);
        simple(CMD_IDENTITY);
        simple(CMD_TRANSLATE, 3 * Q_ONE, -5 * Q_ONE);
        simple(CMD_SCALE, 2 * Q_ONE, -Q_ONE / 2);
        simple(CMD_ROTATE, 0, 0, 16'h4000);
        simple(CMD_ROTATE, 0, 0, 16'hffff);
        simple(CMD_ROTATE, 0, 0, 16'h8000);
        simple(CMD_INVERT);
        simple(CMD_READ);
        send_command(CMD_SET, 32'sh80000000, 1, 32'sh7fffffff, 32'sh80000000, 5, -5, 0);
        simple(CMD_INVERT);
        simple(CMD_READ);
        simple(4'd9);
        simple(4'd15);
        simple(CMD_DELTA, Q_ONE, -Q_ONE);

        // Hold the result side off so the block fills and stalls its input.
        hold_off = 300;
        simple(CMD_READ); simple(CMD_READ); simple(CMD_TRANSFORM, Q_ONE, Q_ONE);

        for (int i = 0; i < 160; i++) begin
            calm = (i >= 60 && i < 100);
            m = $urandom_range(3);
            cmd = $urandom_range(99) < 95 ? 4'($urandom_range(8)) : 4'($urandom_range(15, 9));
            if (cmd == CMD_SET && $urandom_range(3) == 0)
                cmd = CMD_INVERT;
            send_command(cmd, rand_q(m), rand_q(m), rand_q(m), rand_q(m), rand_q($urandom_range(3)),
                         rand_q($urandom_range(3)), $urandom());
            if ($urandom_range(9) == 0)
                simple(CMD_IDENTITY);
        end
        calm = 0;
        s_valid <= 0;

        while (board.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("Sent %0d commands covering all opcodes, saturation and singular inverts;",
                 sent);
        $display("checked %0d result transfers under random stalls.", board.checked);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
